// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define HSLRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HSLRGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/hslrgb_pkg.sv
// Types and constants of the HSL/HSV to RGB converter.
`default_nettype none

package hslrgb_pkg;

  localparam int unsigned QW = 13;             // Q12 channel width, holds 4096
  localparam logic [QW-1:0] QOne = 13'd4096;

  localparam logic [15:0] HueFull   = 16'd5760; // 360 deg in 1/16 deg
  localparam logic [12:0] HueSector = 13'd960;  // 60 deg in 1/16 deg
  localparam logic [15:0] Recip15   = 16'd34953; // ceil(2^19 / 15)

  typedef logic [QW-1:0] q12_t;

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  // Values that ride alongside the secondary-component calculation.
  typedef struct packed {
    sector_e sector;
    q12_t    chroma;
    q12_t    offset;
  } side_t;

endpackage

`default_nettype wire

// File: rtl/hslrgb_xcalc.sv
// Secondary component X = C * (960 - dist) / 960, two register stages.
`default_nettype none

module hslrgb_xcalc (
  input  wire logic                clk_i,
  input  wire hslrgb_pkg::q12_t    chroma_i,
  input  wire logic [9:0]          weight_i,
  output      hslrgb_pkg::q12_t    x_o
);
  import hslrgb_pkg::*;

  logic [21:0] prod;
  logic [15:0] part_d, part_q;
  logic [31:0] quot;
  q12_t        x_d, x_q;

  // divide by 960 = 64 * 15: shift first, then reciprocal of 15
  always_comb begin
    prod   = 22'(chroma_i) * 22'(weight_i);
    part_d = prod[21:6];
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
  end

  // exact floor for part < 74898, part stays below 61441
  always_comb begin
    quot = 32'(part_q) * 32'(Recip15);
    x_d  = quot[31:19];
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign x_o = x_q;

endmodule

`default_nettype wire

// File: rtl/hsl_hsv_to_rgb.sv
// Top level: pipelined HSL/HSV to RGB converter.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  in       | start_i / busy_o   | mode_i, hue_i, saturation_i, brightness_i
//  out      | done_o (strobe)    | red_o, green_o, blue_o
//
// Six register stages; a beat taken at one edge shows on done_o once it has passed
// through all of them. A new beat is taken every cycle; busy_o stays low.
// Stages: clamp/operand, chroma multiply + hue mod 360, sector split,
// C*w multiply, reciprocal multiply, placement and output register.
// Reset clears the valid bits only; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module hsl_hsv_to_rgb (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic               mode_i,
  input  wire logic signed [15:0] hue_i,
  input  wire logic [12:0]        saturation_i,
  input  wire logic [12:0]        brightness_i,
  output      logic               done_o,
  output      logic [12:0]        red_o,
  output      logic [12:0]        green_o,
  output      logic [12:0]        blue_o
);
  import hslrgb_pkg::*;

  // valid bits, one per stage
  logic v1_q, v2_q, v3_q, v4_q, v5_q, done_q;

  // ---------------- stage 1: clamp, hue magnitude, chroma operand
  q12_t        sat_c, bri_c, oper_d;
  logic [15:0] mag_d;
  logic [13:0] twol, dev, tval;

  always_comb begin
    sat_c  = (saturation_i > QOne) ? QOne : saturation_i;
    bri_c  = (brightness_i > QOne) ? QOne : brightness_i;
    mag_d  = hue_i[15] ? (~hue_i + 16'd1) : hue_i;
    twol   = {bri_c, 1'b0};
    dev    = (twol >= 14'(QOne)) ? (twol - 14'(QOne)) : (14'(QOne) - twol);
    tval   = 14'(QOne) - dev;
    oper_d = mode_i ? bri_c : tval[12:0];
  end

  logic        mode1_q;
  logic [15:0] mag1_q;
  q12_t        oper1_q, sat1_q, bri1_q;

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_i;
    mag1_q  <= mag_d;
    oper1_q <= oper_d;
    sat1_q  <= sat_c;
    bri1_q  <= bri_c;
  end

  // ---------------- stage 2: chroma multiply, hue mod 5760
  logic [25:0] cprod;
  q12_t        chroma_d;
  logic [15:0] hsub;
  logic [12:0] hred_d;

  always_comb begin
    cprod    = 26'(oper1_q) * 26'(sat1_q);
    chroma_d = cprod[24:12];
    if (mag1_q >= 16'(5 * HueFull))      hsub = 16'(5 * HueFull);
    else if (mag1_q >= 16'(4 * HueFull)) hsub = 16'(4 * HueFull);
    else if (mag1_q >= 16'(3 * HueFull)) hsub = 16'(3 * HueFull);
    else if (mag1_q >= 16'(2 * HueFull)) hsub = 16'(2 * HueFull);
    else if (mag1_q >= HueFull)          hsub = HueFull;
    else                                 hsub = 16'd0;
    hred_d = 13'(mag1_q - hsub);
  end

  logic        mode2_q;
  logic [12:0] hred2_q;
  q12_t        chroma2_q, bri2_q;

  always_ff @(posedge clk_i) begin
    mode2_q   <= mode1_q;
    hred2_q   <= hred_d;
    chroma2_q <= chroma_d;
    bri2_q    <= bri1_q;
  end

  // ---------------- stage 3: sector, distance weight, offset m
  sector_e     sector_d;
  logic [12:0] pbase;
  logic [10:0] rpos;
  logic [9:0]  hdist, weight_d;
  q12_t        offset_d;

  always_comb begin
    if (hred2_q >= 13'(5 * HueSector)) begin
      sector_d = SEC_M_R;
    end else if (hred2_q >= 13'(4 * HueSector)) begin
      sector_d = SEC_B_M;
    end else if (hred2_q >= 13'(3 * HueSector)) begin
      sector_d = SEC_C_B;
    end else if (hred2_q >= 13'(2 * HueSector)) begin
      sector_d = SEC_G_C;
    end else if (hred2_q >= HueSector) begin
      sector_d = SEC_Y_G;
    end else begin
      sector_d = SEC_R_Y;
    end
    // position inside the current pair of sectors
    if (hred2_q >= 13'(4 * HueSector))      pbase = 13'(4 * HueSector);
    else if (hred2_q >= 13'(2 * HueSector)) pbase = 13'(2 * HueSector);
    else                                    pbase = 13'd0;
    rpos     = 11'(hred2_q - pbase);
    hdist    = (rpos >= 11'(HueSector)) ? 10'(rpos - 11'(HueSector))
                                        : 10'(11'(HueSector) - rpos);
    weight_d = 10'(HueSector) - hdist;
    offset_d = mode2_q ? (bri2_q - chroma2_q) : (bri2_q - (chroma2_q >> 1));
  end

  side_t      side3_q, side4_q, side5_q;
  logic [9:0] weight3_q;

  always_ff @(posedge clk_i) begin
    side3_q   <= '{sector: sector_d, chroma: chroma2_q, offset: offset_d};
    weight3_q <= weight_d;
  end

  // ---------------- stages 4 and 5: X in its own unit
  q12_t x5;

  hslrgb_xcalc u_xcalc (
    .clk_i    (clk_i),
    .chroma_i (side3_q.chroma),
    .weight_i (weight3_q),
    .x_o      (x5)
  );

  always_ff @(posedge clk_i) begin
    side4_q <= side3_q;
    side5_q <= side4_q;
  end

  // ---------------- stage 6: placement, add m, saturate
  q12_t        rc, gc, bc;
  logic [13:0] rsum, gsum, bsum;
  q12_t        red_d, green_d, blue_d;
  q12_t        red_q, green_q, blue_q;

  always_comb begin
    case (side5_q.sector)
      SEC_R_Y: begin rc = side5_q.chroma; gc = x5;             bc = '0;             end
      SEC_Y_G: begin rc = x5;             gc = side5_q.chroma; bc = '0;             end
      SEC_G_C: begin rc = '0;             gc = side5_q.chroma; bc = x5;             end
      SEC_C_B: begin rc = '0;             gc = x5;             bc = side5_q.chroma; end
      SEC_B_M: begin rc = x5;             gc = '0;             bc = side5_q.chroma; end
      default: begin rc = side5_q.chroma; gc = '0;             bc = x5;             end
    endcase
    rsum    = 14'(rc) + 14'(side5_q.offset);
    gsum    = 14'(gc) + 14'(side5_q.offset);
    bsum    = 14'(bc) + 14'(side5_q.offset);
    red_d   = (rsum > 14'(QOne)) ? QOne : rsum[12:0];
    green_d = (gsum > 14'(QOne)) ? QOne : gsum[12:0];
    blue_d  = (bsum > 14'(QOne)) ? QOne : bsum[12:0];
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  // ---------------- valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= v5_q;
    end
  end

  assign busy_o  = 1'b0;
  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

// File: rtl/hslrgb_check.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hslrgb_check (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic [12:0]        saturation_i,
  input wire logic               done_o,
  input wire logic [12:0]        red_o,
  input wire logic [12:0]        green_o,
  input wire logic [12:0]        blue_o
);

  // reset stayed released over the whole pipeline depth
  logic [2:0] up_d, up_q;
  logic       run6, gray, in_range;

  always_comb begin
    up_d = (up_q == 3'd6) ? up_q : (up_q + 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= 3'd0;
    end else begin
      up_q <= up_d;
    end
  end

  assign run6     = (up_q == 3'd6);
  assign gray     = (red_o == green_o) && (green_o == blue_o);
  assign in_range = (red_o <= 13'd4096) && (green_o <= 13'd4096) && (blue_o <= 13'd4096);

  `HSLRGB_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy_o raised")
  `HSLRGB_ASSERT(a_latency, run6 |-> (done_o == $past(start_i && !busy_o, 6)), "late done_o")
  `HSLRGB_ASSERT(a_range, done_o |-> in_range, "channel above 1.0")
  `HSLRGB_ASSERT(a_gray, (run6 && $past(start_i && saturation_i == 13'd0, 6)) |-> (done_o && gray), "not gray")

endmodule

bind hsl_hsv_to_rgb hslrgb_check u_hslrgb_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .saturation_i (saturation_i),
  .done_o       (done_o),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o)
);

`default_nettype wire
